// ----- sv/ccds_pkg.sv -----
// ----------------------------------------------------------------------------
// ccds_pkg
// Shared widths, constants and control types for the clock divider search.
// ----------------------------------------------------------------------------
package ccds_pkg;

	localparam int RATE_W = 29;
	localparam int DIV_W  = 10;
	localparam int FRAC_W = 6;
	// widest dividend: parent * 18 fits in 34 bits
	localparam int NUM_W  = 34;

	localparam logic [FRAC_W-1:0] FRAC_MIN = 6'd18;
	localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd35;

	localparam logic [0:0] REG_PARENT_IS_XTAL = 1'd0;
	localparam logic [0:0] REG_PARENT_RATE    = 1'd1;

	localparam logic [RATE_W-1:0] PARENT_RESET = 29'd480000000;

	// request to the shared divider
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
		logic             rem_nz;
	} div_rsp_t;

endpackage

// ----- sv/ccds_divider.sv -----
// ----------------------------------------------------------------------------
// ccds_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccds_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ccds_pkg::div_req_t req,
	output ccds_pkg::div_rsp_t rsp
);
	import ccds_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [NUM_W-1:0] den_q;
	logic [NUM_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W:0]   shl;
	logic [NUM_W:0]   diff;

	// shift in the next dividend bit and try a subtract
	assign shl  = {rem_q[NUM_W-1:0], quo_q[NUM_W-1]};
	assign diff = shl - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath holds no reset
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[NUM_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shl;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quo    = quo_q;
	assign rsp.rem_nz = (rem_q != '0);

endmodule

// ----- sv/ccds_seq.sv -----
// ----------------------------------------------------------------------------
// ccds_seq
// Search sequencer: issues divisions, walking the divider range in PLL mode.
// ----------------------------------------------------------------------------
module ccds_seq #(
	parameter int PLL_DIV_LIMIT  = 63,
	parameter int XTAL_DIV_LIMIT = 1023,
	parameter int RATE_SHIFT     = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ccds_pkg::RATE_W-1:0]    rate,
	input  logic                           is_xtal,
	input  logic [ccds_pkg::RATE_W-1:0]    parent,
	output ccds_pkg::div_req_t             req,
	input  ccds_pkg::div_rsp_t             rsp,
	output logic                           done,
	output logic                           status,
	output logic [ccds_pkg::DIV_W-1:0]     divider,
	output logic [ccds_pkg::FRAC_W-1:0]    fraction
);
	import ccds_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_XDIV  = 3'd1;
	localparam logic [2:0] ST_QDIV  = 3'd2;
	localparam logic [2:0] ST_FDIV  = 3'd3;
	localparam logic [2:0] ST_CDIV  = 3'd4;
	localparam logic [2:0] ST_NEXT  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]       st_q;
	logic [RATE_W-1:0] r_q;
	logic [RATE_W-1:0] p_q;
	logic [RATE_W-1:0] best_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W-1:0] bd_q;
	logic [FRAC_W-1:0] bf_q;
	logic [NUM_W-1:0] f_q;
	logic             ok_q;
	logic             done_q;
	logic [NUM_W-1:0] p18;
	logic [NUM_W-1:0] fup;
	logic [RATE_W-1:0] shortfall;

	assign p18 = NUM_W'(p_q) * NUM_W'(FRAC_MIN);
	assign fup = rsp.quo + NUM_W'(rsp.rem_nz);
	assign shortfall = r_q - rsp.quo[RATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						ok_q <= 1'b0;
						if (rate == '0) begin
							st_q <= ST_FIN;
						end else if (is_xtal) begin
							r_q  <= rate;
							p_q  <= parent;
							st_q <= ST_XDIV;
						end else if ((rate >> RATE_SHIFT) == '0) begin
							st_q <= ST_FIN;
						end else begin
							r_q    <= rate >> RATE_SHIFT;
							p_q    <= parent >> RATE_SHIFT;
							best_q <= parent >> RATE_SHIFT;
							d_q    <= DIV_W'(1);
							bd_q   <= DIV_W'(1);
							bf_q   <= FRAC_W'(1);
							st_q   <= ST_QDIV;
						end
					end
				end
				ST_XDIV: begin
					// rounded-up parent / rate
					if (rsp.done) begin
						if (fup != '0 && fup <= NUM_W'(XTAL_DIV_LIMIT)) begin
							ok_q <= 1'b1;
							bd_q <= fup[DIV_W-1:0];
							bf_q <= '0;
						end
						st_q <= ST_FIN;
					end
				end
				ST_QDIV: begin
					// q = p*18/d; then divide q by r, rounding up
					if (rsp.done) begin
						f_q  <= rsp.quo;
						st_q <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (rsp.done) begin
						if (fup < NUM_W'(FRAC_MIN) || fup > NUM_W'(FRAC_MAX)) begin
							st_q <= ST_NEXT;
						end else begin
							f_q  <= fup;
							st_q <= ST_CDIV;
						end
					end
				end
				ST_CDIV: begin
					// calc = p*18/(f*d), same as chained floor divides
					if (rsp.done) begin
						st_q <= ST_NEXT;
						if (rsp.quo <= NUM_W'(r_q) && shortfall < best_q) begin
							best_q <= shortfall;
							bd_q   <= d_q;
							bf_q   <= f_q[FRAC_W-1:0];
						end
					end
				end
				ST_NEXT: begin
					if (best_q == '0 || d_q == DIV_W'(PLL_DIV_LIMIT)) begin
						ok_q <= (best_q != p_q);
						st_q <= ST_FIN;
					end else begin
						d_q  <= d_q + 1'b1;
						st_q <= ST_QDIV;
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// issue a division on entry to each divide state
	logic [2:0] st_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_d <= ST_IDLE;
		else         st_d <= st_q;
	end

	always_comb begin
		req.start = (st_q != st_d) &&
			(st_q == ST_XDIV || st_q == ST_QDIV || st_q == ST_FDIV || st_q == ST_CDIV);
		req.num = NUM_W'(p_q);
		req.den = NUM_W'(r_q);
		unique case (st_q)
			ST_QDIV: begin
				req.num = p18;
				req.den = NUM_W'(d_q);
			end
			ST_FDIV: begin
				req.num = f_q;
				req.den = NUM_W'(r_q);
			end
			ST_CDIV: begin
				req.num = p18;
				req.den = NUM_W'(f_q[FRAC_W-1:0]) * NUM_W'(d_q);
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign status   = !ok_q;
	assign divider  = ok_q ? bd_q : '0;
	assign fraction = ok_q ? bf_q : '0;

endmodule

// ----- sv/cpu_clock_divider_search_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_clock_divider_search_unit
// Finds divider and fractional settings nearest at or below a requested CPU rate.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | tdata[28:0] target_rate_hz
// m_axis  | out | tdata[0] status, [10:1] divider, [16:11] fraction
// cfg     | in  | we, idx, wdata (0 parent_is_xtal, 1 parent_rate_hz)
//
// All divisions run on the one shared radix-2 divider. Crystal mode needs
// one division; PLL mode up to three per divider step, up to PLL_DIV_LIMIT
// steps. One word in flight; s_axis_tready drops from accept until the
// result is taken. Reset clears control state and loads the register reset
// values.
module cpu_clock_divider_search_unit #(
	parameter int PLL_DIV_LIMIT  = 63,
	parameter int XTAL_DIV_LIMIT = 1023,
	parameter int RATE_SHIFT     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [28:0] target_rate_hz
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] status, [10:1] divider, [16:11] fraction
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [28:0] cfg_wdata
);
	import ccds_pkg::*;

	logic              is_xtal_q;
	logic [RATE_W-1:0] parent_q;
	logic              busy_q;
	logic              out_v_q;
	logic [16:0]       out_q;
	div_req_t          req;
	div_rsp_t          rsp;
	logic              sdone;
	logic              st;
	logic [DIV_W-1:0]  dv;
	logic [FRAC_W-1:0] fr;
	logic              acc;

	assign s_axis_tready = !busy_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_xtal_q <= 1'b0;
			parent_q  <= PARENT_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == REG_PARENT_IS_XTAL) is_xtal_q <= cfg_wdata[0];
			else                               parent_q  <= cfg_wdata;
		end
	end

	ccds_seq #(
		.PLL_DIV_LIMIT (PLL_DIV_LIMIT),
		.XTAL_DIV_LIMIT(XTAL_DIV_LIMIT),
		.RATE_SHIFT    (RATE_SHIFT)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc),
		.rate    (s_axis_tdata[RATE_W-1:0]),
		.is_xtal (is_xtal_q),
		.parent  (parent_q),
		.req     (req),
		.rsp     (rsp),
		.done    (sdone),
		.status  (st),
		.divider (dv),
		.fraction(fr)
	);

	ccds_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// hold busy until the result word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) busy_q <= 1'b1;
			if (sdone) out_v_q <= 1'b1;
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
				busy_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sdone) out_q <= {fr, dv, st};
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_q};

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> busy_q) else $error("result without request");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sdone |-> (busy_q && !out_v_q)) else $error("search done while idle");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q[0]) |-> (out_q[16:1] == '0)) else $error("bad fail word");

endmodule

// ----- sim/cpu_clock_divider_search_unit_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_clock_divider_search_unit_tb
// Drives rate requests through the divider search, predicts every result
// word from a behavioral search and compares status, divider and fraction.
// ----------------------------------------------------------------------------
class rate_scoreboard;
	logic [16:0] pending_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// note an accepted request and its predicted result
	function void note_request(logic [16:0] predicted);
		pending_q.push_back(predicted);
	endfunction

	// compare one result word with the oldest prediction
	function void check_result(logic [23:0] got);
		logic [16:0] want;
		if (pending_q.size() == 0) begin
			report_err("result with nothing pending", 0, got);
			return;
		end
		want = pending_q.pop_front();
		if (got[0] !== want[0]) report_err("status", want[0], got[0]);
		if (got[10:1] !== want[10:1]) report_err("divider", want[10:1], got[10:1]);
		if (got[16:11] !== want[16:11]) report_err("fraction", want[16:11], got[16:11]);
	endfunction

	function void report_err(string what, logic [23:0] want, logic [23:0] got);
		errors++;
		$display("error: %s expected %0d got %0d", what, want, got);
	endfunction
endclass

module cpu_clock_divider_search_unit_tb;
	import ccds_pkg::*;

	localparam int PLL_LIM = 63;
	localparam int XTAL_LIM = 1023;
	localparam int SHIFT = 8;
	localparam longint CYCLE_LIMIT = 64'd6000000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 0;
	logic cfg_idx = 0;
	logic [28:0] cfg_wdata = 0;

	logic sel_xtal;
	logic [28:0] sel_parent;
	rate_scoreboard sb;
	longint cycles = 0;
	bit hold_off = 0;
	bit sending_done = 0;

	cpu_clock_divider_search_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cpu_clock_divider_search_unit: mismatch");
			$finish;
		end
	end

	function automatic longint unsigned ceil_div(longint unsigned n, longint unsigned d);
		return n / d + ((n % d) != 0 ? 1 : 0);
	endfunction

	// search the divider settings for one requested rate
	function automatic logic [16:0] predict_setting(logic [28:0] rate);
		longint unsigned r, p, best, bd, bf, q, f, calc, dv;
		logic [16:0] res;
		res = 17'd1;
		if (rate == 0) return res;
		if (sel_xtal) begin
			dv = ceil_div(sel_parent, rate);
			if (dv != 0 && dv <= XTAL_LIM) res = {6'd0, dv[9:0], 1'b0};
			return res;
		end
		r = rate >> SHIFT;
		p = sel_parent >> SHIFT;
		best = p;
		bd = 1;
		bf = 1;
		if (r == 0) return res;
		for (int d = 1; d <= PLL_LIM; d++) begin
			q = p * FRAC_MIN / d;
			f = ceil_div(q, r);
			if (f < FRAC_MIN || f > FRAC_MAX) continue;
			calc = p * FRAC_MIN / f / d;
			if (calc > r) continue;
			if (r - calc < best) begin
				best = r - calc;
				bd = d;
				bf = f;
			end
			if (best == 0) break;
		end
		if (best != p) res = {bf[5:0], bd[9:0], 1'b0};
		return res;
	endfunction

	task automatic write_reg(logic idx, logic [28:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		cfg_wdata = 29'($urandom);
		if (idx == REG_PARENT_IS_XTAL) sel_xtal = val[0];
		else sel_parent = val;
	endtask

	// offer one request word after a random gap
	task automatic send_rate(logic [28:0] rate);
		repeat ($urandom_range(0, 14)) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = {3'($urandom_range(0, 7)), rate};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(predict_setting(rate));
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic wait_idle();
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [28:0] random_rate();
		case ($urandom_range(0, 5))
			0: return 29'($urandom_range(0, 600));
			1: return 29'($urandom_range(0, 480000000));
			2: return 29'h1FFFFFFF ^ 29'($urandom);
			3: return 29'(sel_parent / $urandom_range(1, 80));
			default: return 29'($urandom_range(1000000, 480000000));
		endcase
	endfunction

	// receive side: random stalls, one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) m_axis_tready = 0;
			else m_axis_tready = ($urandom_range(0, 14) < 9) || sending_done;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

	initial begin
		logic [28:0] parents[6];
		sb = new();
		sel_xtal = 0;
		sel_parent = 29'd480000000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: PLL mode, full parent rate
		send_rate(0);
		send_rate(255);
		send_rate(256);
		send_rate(29'd480000000);
		send_rate(29'h1FFFFFFF);
		send_rate(29'd480000000 / 18);
		send_rate(29'd200000000);
		send_rate(29'd1000000);
		wait_idle();

		// crystal mode cases, including zero parent and oversize divider
		write_reg(REG_PARENT_IS_XTAL, 1);
		write_reg(REG_PARENT_RATE, 29'd24000000);
		send_rate(29'd24000000);
		send_rate(29'd1);
		send_rate(29'd23460);
		send_rate(29'd23461);
		send_rate(29'h1FFFFFFF);
		send_rate(0);
		wait_idle();
		write_reg(REG_PARENT_RATE, 0);
		send_rate(29'd1000);
		wait_idle();
		write_reg(REG_PARENT_RATE, 29'h1FFFFFFF);
		send_rate(29'd1);
		send_rate(29'd7);
		wait_idle();

		// pressure: receiver holds off while requests keep coming
		write_reg(REG_PARENT_IS_XTAL, 0);
		write_reg(REG_PARENT_RATE, 29'd480000000);
		fork
			begin
				hold_off = 1;
				repeat (20000) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_rate(29'd100000000);
				send_rate(29'd64000000);
				send_rate(29'd300);
			end
		join
		wait_idle();

		// random phases across several parent settings
		parents = '{29'd480000000, 29'd0, 29'h1FFFFFFF, 29'd24000000, 29'd600, 29'd0};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_PARENT_IS_XTAL, 1'($urandom_range(0, 1)));
			if (ph < 6) write_reg(REG_PARENT_RATE, parents[ph] == 0 && ph == 5 ?
				29'($urandom) : parents[ph]);
			else write_reg(REG_PARENT_RATE, 29'($urandom_range(0, 480000000)));
			for (int i = 0; i < 15; i++) send_rate(random_rate());
			wait_idle();
		end

		sending_done = 1;
		wait_idle();
		if (sb.errors == 0) begin
			$display("cpu_clock_divider_search_unit: match");
		end else begin
			$display("cpu_clock_divider_search_unit: mismatch");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/ccds_pkg.sv
sv/ccds_divider.sv
sv/ccds_seq.sv
sv/cpu_clock_divider_search_unit.sv
sim/cpu_clock_divider_search_unit_tb.sv
